### hw/rtl/rqc_pkg.sv
package rqc_pkg;

  // Coordinate and angle field widths.
  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int NUM_VERT   = 4;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_FIELD_BITS  = 2 * NUM_VERT * COORD_BITS + ANGLE_BITS;
  localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * NUM_VERT * COORD_BITS;
  localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Datapath widths of the rotation arithmetic.
  localparam int SUM_W     = COORD_BITS + 2;    // sum of four coordinates
  localparam int DIFF_W    = COORD_BITS + 3;    // 4*p - sum
  localparam int CS_W      = 17;                // Q1.15 cosine/sine incl. +1.0
  localparam int PROD_W    = DIFF_W + CS_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int RND_SHIFT = 17;
  localparam int RES_W     = ACC_W - RND_SHIFT;
  localparam int Q15_ONE   = 32768;

  // Angle reduction.
  localparam int ANG_X_W      = ANGLE_BITS + 1;
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int REM_W        = 13;
  localparam int Z_SHIFT      = 10;

  // CORDIC chain.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 33;
  localparam int Z_W          = REM_W + Z_SHIFT + 1;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

  // Pipeline registers behind the CORDIC chain.
  localparam int ROT_STAGES  = 3;
  localparam int PIPE_STAGES = 1 + CORDIC_STEPS + ROT_STAGES;

  // Quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Data handed from cell to cell.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
    logic                   rzero;
  } rqc_cord_t;

  // Vertices and coordinate sums that travel beside the chain.
  typedef struct packed {
    logic [NUM_VERT-1:0][COORD_BITS-1:0] px;
    logic [NUM_VERT-1:0][COORD_BITS-1:0] py;
    logic signed [SUM_W-1:0]             sx;
    logic signed [SUM_W-1:0]             sy;
  } rqc_pay_t;

  // Rotated vertices.
  typedef struct packed {
    logic [NUM_VERT-1:0][COORD_BITS-1:0] rx;
    logic [NUM_VERT-1:0][COORD_BITS-1:0] ry;
  } rqc_res_t;

  // Arctangent of 2^-i in units of 2^-16 degree.
  function automatic logic signed [Z_W-1:0] atan_val(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      4'd0:    v = Z_W'(2949120);
      4'd1:    v = Z_W'(1740967);
      4'd2:    v = Z_W'(919879);
      4'd3:    v = Z_W'(466945);
      4'd4:    v = Z_W'(234379);
      4'd5:    v = Z_W'(117304);
      4'd6:    v = Z_W'(58666);
      4'd7:    v = Z_W'(29335);
      4'd8:    v = Z_W'(14668);
      4'd9:    v = Z_W'(7334);
      4'd10:   v = Z_W'(3667);
      4'd11:   v = Z_W'(1833);
      4'd12:   v = Z_W'(917);
      4'd13:   v = Z_W'(458);
      4'd14:   v = Z_W'(229);
      default: v = Z_W'(115);
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/rqc_front.sv
module rqc_front
  import rqc_pkg::*;
(
  input  logic                                clk,
  input  logic                                en,
  input  logic [NUM_VERT-1:0][COORD_BITS-1:0] px,
  input  logic [NUM_VERT-1:0][COORD_BITS-1:0] py,
  input  logic [ANGLE_BITS-1:0]               angle,
  output rqc_cord_t                           cord_r,
  output rqc_pay_t                            pay_r
);

  localparam logic signed [ANG_X_W-1:0] FT  = ANG_X_W'(FULL_TURN);
  localparam logic signed [ANG_X_W-1:0] QT1 = ANG_X_W'(QUARTER_TURN);
  localparam logic signed [ANG_X_W-1:0] QT2 = ANG_X_W'(2 * QUARTER_TURN);
  localparam logic signed [ANG_X_W-1:0] QT3 = ANG_X_W'(3 * QUARTER_TURN);

  logic signed [ANG_X_W-1:0] ax;
  logic signed [ANG_X_W-1:0] aw;
  logic signed [ANG_X_W-1:0] adiff;
  logic [REM_W-1:0]          rem;
  rqc_cord_t                 cord_nxt;
  rqc_pay_t                  pay_nxt;

  // Wrap the angle into one turn, then split off the quadrant.
  always_comb begin
    ax = {angle[ANGLE_BITS-1], angle};
    if (ax[ANG_X_W-1]) begin
      aw = ax + FT;
      if (aw[ANG_X_W-1]) begin
        aw = aw + FT;
      end
    end else if (ax >= FT) begin
      aw = ax - FT;
    end else begin
      aw = ax;
    end

    if (aw >= QT3) begin
      cord_nxt.quad = QUAD_3;
      adiff         = aw - QT3;
    end else if (aw >= QT2) begin
      cord_nxt.quad = QUAD_2;
      adiff         = aw - QT2;
    end else if (aw >= QT1) begin
      cord_nxt.quad = QUAD_1;
      adiff         = aw - QT1;
    end else begin
      cord_nxt.quad = QUAD_0;
      adiff         = aw;
    end
    rem            = adiff[REM_W-1:0];
    cord_nxt.rzero = (rem == '0);
    cord_nxt.x     = CORDIC_X0;
    cord_nxt.y     = '0;
    cord_nxt.z     = Z_W'({rem, {Z_SHIFT{1'b0}}});
  end

  // Coordinate sums; four times the centroid.
  always_comb begin
    pay_nxt.px = px;
    pay_nxt.py = py;
    pay_nxt.sx = '0;
    pay_nxt.sy = '0;
    for (int k = 0; k < NUM_VERT; k++) begin
      pay_nxt.sx = pay_nxt.sx + SUM_W'(signed'(px[k]));
      pay_nxt.sy = pay_nxt.sy + SUM_W'(signed'(py[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cord_r <= cord_nxt;
      pay_r  <= pay_nxt;
    end
  end

endmodule

### hw/rtl/rqc_cordic_cell.sv
module rqc_cordic_cell
  import rqc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  rqc_cord_t         din,
  output rqc_cord_t         dout_r
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  da;
  rqc_cord_t              dout_nxt;

  // One rotation-mode micro-rotation; direction follows the sign of z.
  always_comb begin
    dx       = din.y >>> step;
    dy       = din.x >>> step;
    da       = atan_val(step);
    dout_nxt = din;
    if (!din.z[Z_W-1]) begin
      dout_nxt.x = din.x - dx;
      dout_nxt.y = din.y + dy;
      dout_nxt.z = din.z - da;
    end else begin
      dout_nxt.x = din.x + dx;
      dout_nxt.y = din.y - dy;
      dout_nxt.z = din.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

endmodule

### hw/rtl/rqc_rotate.sv
module rqc_rotate
  import rqc_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  rqc_cord_t cord,
  input  rqc_pay_t  pay,
  output rqc_res_t  res_r
);

  localparam logic signed [XY_W-1:0]  ONE_X  = XY_W'(Q15_ONE);
  localparam logic signed [XY_W-1:0]  HALF_X = XY_W'(Q15_ONE / 2);
  localparam logic signed [CS_W-1:0]  ONE_CS = CS_W'(Q15_ONE);
  localparam logic signed [ACC_W-1:0] HALF_T = ACC_W'(1) <<< (RND_SHIFT - 1);

  // Round a Q2.30 CORDIC output to Q1.15 and clamp to +-1.0.
  function automatic logic signed [CS_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] q;
    logic signed [CS_W-1:0] r;
    q = (v + HALF_X) >>> 15;
    if (q > ONE_X) begin
      r = ONE_CS;
    end else if (q < -ONE_X) begin
      r = -ONE_CS;
    end else begin
      r = q[CS_W-1:0];
    end
    return r;
  endfunction

  // Round to nearest and saturate to the coordinate range.
  function automatic logic [COORD_BITS-1:0] finish(input logic signed [ACC_W-1:0] t);
    logic signed [ACC_W-1:0] tr;
    logic [RES_W-1:0]        v;
    logic [COORD_BITS-1:0]   r;
    tr = t + HALF_T;
    v  = tr[ACC_W-1:RND_SHIFT];
    if (v[RES_W-1:COORD_BITS-1] == '0 || v[RES_W-1:COORD_BITS-1] == '1) begin
      r = v[COORD_BITS-1:0];
    end else if (v[RES_W-1]) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  logic signed [CS_W-1:0]   cc;
  logic signed [CS_W-1:0]   ss;
  logic signed [CS_W-1:0]   c_nxt;
  logic signed [CS_W-1:0]   s_nxt;
  logic signed [CS_W-1:0]   c_r;
  logic signed [CS_W-1:0]   s_r;
  logic signed [DIFF_W-1:0] dx_r  [NUM_VERT];
  logic signed [DIFF_W-1:0] dy_r  [NUM_VERT];
  logic signed [SUM_W-1:0]  sx_a_r;
  logic signed [SUM_W-1:0]  sy_a_r;
  logic signed [PROD_W-1:0] pxc_r [NUM_VERT];
  logic signed [PROD_W-1:0] pys_r [NUM_VERT];
  logic signed [PROD_W-1:0] pxs_r [NUM_VERT];
  logic signed [PROD_W-1:0] pyc_r [NUM_VERT];
  logic signed [SUM_W-1:0]  sx_b_r;
  logic signed [SUM_W-1:0]  sy_b_r;
  logic signed [ACC_W-1:0]  tx_r  [NUM_VERT];
  logic signed [ACC_W-1:0]  ty_r  [NUM_VERT];

  // Cosine and sine of the reduced angle, mapped back to its quadrant.
  always_comb begin
    if (cord.rzero) begin
      cc = ONE_CS;
      ss = '0;
    end else begin
      cc = to_q15(cord.x);
      ss = to_q15(cord.y);
    end
    unique case (cord.quad)
      QUAD_0: begin
        c_nxt = cc;
        s_nxt = ss;
      end
      QUAD_1: begin
        c_nxt = -ss;
        s_nxt = cc;
      end
      QUAD_2: begin
        c_nxt = -cc;
        s_nxt = -ss;
      end
      QUAD_3: begin
        c_nxt = ss;
        s_nxt = -cc;
      end
    endcase
  end

  // Stage A: cosine/sine and offsets from the centroid, in quarter units.
  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_nxt;
      s_r    <= s_nxt;
      sx_a_r <= pay.sx;
      sy_a_r <= pay.sy;
      for (int k = 0; k < NUM_VERT; k++) begin
        dx_r[k] <= (DIFF_W'(signed'(pay.px[k])) <<< 2) - DIFF_W'(pay.sx);
        dy_r[k] <= (DIFF_W'(signed'(pay.py[k])) <<< 2) - DIFF_W'(pay.sy);
      end
    end
  end

  // Stage B: the four products of each vertex.
  always_ff @(posedge clk) begin
    if (en) begin
      sx_b_r <= sx_a_r;
      sy_b_r <= sy_a_r;
      for (int k = 0; k < NUM_VERT; k++) begin
        pxc_r[k] <= dx_r[k] * c_r;
        pys_r[k] <= dy_r[k] * s_r;
        pxs_r[k] <= dx_r[k] * s_r;
        pyc_r[k] <= dy_r[k] * c_r;
      end
    end
  end

  // Stage C: rotated offset plus the centroid, scaled by 2^17.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        tx_r[k] <= ACC_W'(pxc_r[k]) - ACC_W'(pys_r[k]) + (ACC_W'(sx_b_r) <<< 15);
        ty_r[k] <= ACC_W'(pxs_r[k]) + ACC_W'(pyc_r[k]) + (ACC_W'(sy_b_r) <<< 15);
      end
    end
  end

  // Output register: rounded and saturated coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        res_r.rx[k] <= finish(tx_r[k]);
        res_r.ry[k] <= finish(ty_r[k]);
      end
    end
  end

endmodule

### hw/rtl/rotate_quad_about_centroid.sv
// Rotates one quad of four Q12.4 vertices about its centroid per transaction.
// Input stream: in_tdata carries x0,y0,x1,y1,x2,y2,x3,y3 and turn_angle
// (1/64 degree, counterclockwise positive); one transaction is one quad.
// Output stream: out_tdata carries rx0,ry0,...,rx3,ry3, rounded to nearest
// and saturated to the coordinate range; one result per input transaction.
// Path: each input transaction passes the front register, the 16 CORDIC cells
// and the four rotation stages (the last one is the output register) before
// its result shows on out_tvalid.
// Throughput: one quad per cycle unless stalled; every stage advances together.
// Stall: while out_tvalid is high and out_tready low, the whole pipeline
// holds and in_tready is low; in_tready is high whenever the output register
// is empty or being taken, including the cycle it is taken.
// Reset: rst_n low clears all valid flags; data registers are not reset and
// no result is lost or invented across a stall.
module rotate_quad_about_centroid
  import rqc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x0, y0, x1, y1, x2, y2, x3, y3, turn_angle
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // rx0, ry0, rx1, ry1, rx2, ry2, rx3, ry3
);

  logic                                adv;
  logic [PIPE_STAGES-1:0]              vld_r;
  logic                                out_valid_r;
  logic [NUM_VERT-1:0][COORD_BITS-1:0] px;
  logic [NUM_VERT-1:0][COORD_BITS-1:0] py;
  logic [ANGLE_BITS-1:0]               angle;
  rqc_cord_t                           chain [CORDIC_STEPS+1];
  rqc_pay_t                            pay_front;
  rqc_pay_t                            pay_line_r [CORDIC_STEPS];
  rqc_res_t                            res;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;

  // Unpack the input transaction.
  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      px[k] = in_tdata[(2*k)*COORD_BITS +: COORD_BITS];
      py[k] = in_tdata[(2*k+1)*COORD_BITS +: COORD_BITS];
    end
    angle = in_tdata[2*NUM_VERT*COORD_BITS +: ANGLE_BITS];
  end

  // Valid flags follow the items through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_STAGES-2:0], in_tvalid};
      out_valid_r <= vld_r[PIPE_STAGES-1];
    end
  end

  rqc_front u_front (
    .clk    (clk),
    .en     (adv),
    .px     (px),
    .py     (py),
    .angle  (angle),
    .cord_r (chain[0]),
    .pay_r  (pay_front)
  );

  // Row of CORDIC cells, one micro-rotation each.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    rqc_cordic_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .step   (STEP_W'(i)),
      .din    (chain[i]),
      .dout_r (chain[i+1])
    );
  end

  // Vertices wait beside the cell row.
  always_ff @(posedge clk) begin
    if (adv) begin
      pay_line_r[0] <= pay_front;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        pay_line_r[k] <= pay_line_r[k-1];
      end
    end
  end

  rqc_rotate u_rotate (
    .clk   (clk),
    .en    (adv),
    .cord  (chain[CORDIC_STEPS]),
    .pay   (pay_line_r[CORDIC_STEPS-1]),
    .res_r (res)
  );

  // Pack the result transaction.
  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < NUM_VERT; k++) begin
      out_tdata[(2*k)*COORD_BITS +: COORD_BITS]   = res.rx[k];
      out_tdata[(2*k+1)*COORD_BITS +: COORD_BITS] = res.ry[k];
    end
  end

endmodule

### hw/rtl/rqc_checker.sv
module rqc_checker
  import rqc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A stalled result stays and keeps its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // An empty or draining output register lets a new transaction in.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("in_tready low with output free");

  // A stalled output register freezes the pipeline input.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("in_tready high while output stalled");

endmodule

bind rotate_quad_about_centroid rqc_checker u_rqc_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rqc_pkg::*;

  // Angle units are 1/64 degree; the sine and cosine come out in Q1.15.
  localparam longint DEG360      = 23040;
  localparam longint DEG90       = 5760;
  localparam int     ROT_ITERS   = 16;
  localparam longint GAIN_Q30    = 652032874;
  localparam longint UNIT_Q15    = 32768;
  localparam int     RANDOM_QUADS = 2000;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     HOLD_OFF_AT  = 700;
  localparam int     HOLD_OFF_LEN = 300;

  // One row of the directed plan; fixed rows carry a hand-worked result.
  typedef struct {
    logic [IN_DATA_W-1:0]  stim;
    bit                    fixed;
    logic [OUT_DATA_W-1:0] res;
  } quad_case_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // x0, y0, x1, y1, x2, y2, x3, y3, turn_angle
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // rx0, ry0, rx1, ry1, rx2, ry2, rx3, ry3

  // Result that goes with the quad on the bus, when it is a hand-worked row.
  logic                  cur_fixed = 1'b0;
  logic [OUT_DATA_W-1:0] cur_fixed_res = '0;

  logic [OUT_DATA_W-1:0] rotated_due [$];
  longint                atan_q16 [ROT_ITERS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };
  int                    quads_sent = 0;
  int                    quads_checked = 0;
  int                    mismatch_count = 0;
  int                    burst_left = 0;
  bit                    stim_done = 1'b0;

  rotate_quad_about_centroid dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Packs one quad and its angle into the input word, x0 in the lowest bits.
  function automatic logic [IN_DATA_W-1:0] quad_in(input int x0, input int y0, input int x1,
                                                   input int y1, input int x2, input int y2,
                                                   input int x3, input int y3, input int ang);
    return {ANGLE_BITS'(ang), COORD_BITS'(y3), COORD_BITS'(x3), COORD_BITS'(y2),
            COORD_BITS'(x2), COORD_BITS'(y1), COORD_BITS'(x1), COORD_BITS'(y0),
            COORD_BITS'(x0)};
  endfunction

  function automatic logic [OUT_DATA_W-1:0] quad_res(input int x0, input int y0, input int x1,
                                                     input int y1, input int x2, input int y2,
                                                     input int x3, input int y3);
    return {COORD_BITS'(y3), COORD_BITS'(x3), COORD_BITS'(y2), COORD_BITS'(x2),
            COORD_BITS'(y1), COORD_BITS'(x1), COORD_BITS'(y0), COORD_BITS'(x0)};
  endfunction

  // Cosine and sine in Q1.15 by reducing to one quadrant and a 16-step CORDIC.
  function automatic void angle_to_unit_vector(input longint ang, output longint cos_q,
                                               output longint sin_q);
    longint     a, r, cx, cy, z, sx, sy, cc, ss;
    logic [1:0] quad;
    a = ang % DEG360;
    if (a < 0) begin
      a = a + DEG360;
    end
    quad = 2'(a / DEG90);
    r = a % DEG90;
    if (r == 0) begin
      cc = UNIT_Q15;
      ss = 0;
    end else begin
      cx = GAIN_Q30;
      cy = 0;
      z = r * 1024;
      for (int i = 0; i < ROT_ITERS; i++) begin
        sx = cy >>> i;
        sy = cx >>> i;
        if (z >= 0) begin
          cx = cx - sx;
          cy = cy + sy;
          z = z - atan_q16[i];
        end else begin
          cx = cx + sx;
          cy = cy - sy;
          z = z + atan_q16[i];
        end
      end
      // Round Q2.30 to Q1.15 and keep within +-1.0.
      cc = (cx + 16384) >>> 15;
      ss = (cy + 16384) >>> 15;
      if (cc > UNIT_Q15) cc = UNIT_Q15;
      if (cc < -UNIT_Q15) cc = -UNIT_Q15;
      if (ss > UNIT_Q15) ss = UNIT_Q15;
      if (ss < -UNIT_Q15) ss = -UNIT_Q15;
    end
    case (quad)
      QUAD_1: begin
        cos_q = -ss;
        sin_q = cc;
      end
      QUAD_2: begin
        cos_q = -cc;
        sin_q = -ss;
      end
      QUAD_3: begin
        cos_q = ss;
        sin_q = -cc;
      end
      default: begin
        cos_q = cc;
        sin_q = ss;
      end
    endcase
  endfunction

  // Rotates the four vertices about their exact centroid, then rounds and saturates.
  function automatic logic [OUT_DATA_W-1:0] rotate_about_centroid(
      input logic [IN_DATA_W-1:0] quad);
    longint                vx [NUM_VERT];
    longint                vy [NUM_VERT];
    longint                sum_x, sum_y, cos_q, sin_q, dx, dy, tx, ty, hi, lo;
    logic [OUT_DATA_W-1:0] res;
    sum_x = 0;
    sum_y = 0;
    for (int k = 0; k < NUM_VERT; k++) begin
      vx[k] = longint'($signed(quad[2*k*COORD_BITS +: COORD_BITS]));
      vy[k] = longint'($signed(quad[(2*k+1)*COORD_BITS +: COORD_BITS]));
      sum_x = sum_x + vx[k];
      sum_y = sum_y + vy[k];
    end
    angle_to_unit_vector(longint'($signed(quad[2*NUM_VERT*COORD_BITS +: ANGLE_BITS])),
                         cos_q, sin_q);
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    for (int k = 0; k < NUM_VERT; k++) begin
      dx = vx[k] * 4 - sum_x;
      dy = vy[k] * 4 - sum_y;
      tx = (dx * cos_q - dy * sin_q + sum_x * UNIT_Q15 + 65536) >>> 17;
      ty = (dx * sin_q + dy * cos_q + sum_y * UNIT_Q15 + 65536) >>> 17;
      if (tx > hi) tx = hi;
      if (tx < lo) tx = lo;
      if (ty > hi) ty = hi;
      if (ty < lo) ty = lo;
      res[2*k*COORD_BITS +: COORD_BITS] = COORD_BITS'(tx);
      res[(2*k+1)*COORD_BITS +: COORD_BITS] = COORD_BITS'(ty);
    end
    return res;
  endfunction

  // Clamps a coordinate to the signed field range.
  function automatic int clamp_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mostly compact quads around a random center, some with fully random corners.
  function automatic logic [IN_DATA_W-1:0] random_quad();
    logic [IN_DATA_W-1:0] quad;
    int                   cx, cy, spread, ang, sel;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    spread = 1 << $urandom_range(0, 14);
    for (int f = 0; f < 2 * NUM_VERT; f++) begin
      if ($urandom_range(0, 4) == 0) begin
        quad[f*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
      end else begin
        quad[f*COORD_BITS +: COORD_BITS] =
          COORD_BITS'(clamp_coord(((f % 2) ? cy : cx) +
                                  int'($urandom_range(0, 2 * spread)) - spread));
      end
    end
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      ang = int'($urandom_range(0, 7)) * int'(DEG90) - int'(DEG360);
    end else if (sel == 1) begin
      ang = int'($urandom_range(0, 65535)) - 32768;
    end else if (sel == 2) begin
      ang = int'($urandom_range(0, 128)) - 64;
    end else begin
      ang = int'($urandom_range(0, 46079)) - int'(DEG360);
    end
    quad[2*NUM_VERT*COORD_BITS +: ANGLE_BITS] = ANGLE_BITS'(ang);
    return quad;
  endfunction

  // Offers one quad, in bursts of random length with random gaps, until taken.
  task automatic offer_quad(input logic [IN_DATA_W-1:0] quad, input bit fixed,
                            input logic [OUT_DATA_W-1:0] fixed_res);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= quad;
    cur_fixed <= fixed;
    cur_fixed_res <= fixed_res;
    do @(posedge clk); while (!in_tready);
  endtask

  // Source: the directed plan first, then random quads.
  initial begin : source
    quad_case_t plan [$];
    plan.push_back(quad_case_t'{quad_in(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                quad_res(0, 0, 0, 0, 0, 0, 0, 0)});
    plan.push_back(quad_case_t'{quad_in(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                        32767, 0), 1'b1,
                                quad_res(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                         32767)});
    plan.push_back(quad_case_t'{quad_in(-32768, -32768, -32768, -32768, -32768, -32768,
                                        -32768, -32768, 0), 1'b1,
                                quad_res(-32768, -32768, -32768, -32768, -32768, -32768,
                                         -32768, -32768)});
    // A degenerate quad sits on its centroid whatever the angle.
    plan.push_back(quad_case_t'{quad_in(-32768, -32768, -32768, -32768, -32768, -32768,
                                        -32768, -32768, 7000), 1'b1,
                                quad_res(-32768, -32768, -32768, -32768, -32768, -32768,
                                         -32768, -32768)});
    plan.push_back(quad_case_t'{quad_in(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                        32767, -9000), 1'b1,
                                quad_res(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                         32767)});
    // A square centered on the origin at the exact quarter turns.
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, 0), 1'b1,
                                quad_res(-100, -100, 100, -100, 100, 100, -100, 100)});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, 5760),
                                1'b1, quad_res(100, -100, 100, 100, -100, 100, -100, -100)});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, 11520),
                                1'b1, quad_res(100, 100, -100, 100, -100, -100, 100, -100)});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, 17280),
                                1'b1, quad_res(-100, 100, -100, -100, 100, -100, 100, 100)});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, -5760),
                                1'b1, quad_res(-100, 100, -100, -100, 100, -100, 100, 100)});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, -23040),
                                1'b1, quad_res(-100, -100, 100, -100, 100, 100, -100, 100)});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, 23040),
                                1'b1, quad_res(-100, -100, 100, -100, 100, 100, -100, 100)});
    // Half turns that tie on rounding and saturate at both ends.
    plan.push_back(quad_case_t'{quad_in(32767, 32767, 32767, 32767, 32767, 32767, -32768,
                                        -32768, 11520), 1'b1,
                                quad_res(0, 0, 0, 0, 0, 0, 32767, 32767)});
    plan.push_back(quad_case_t'{quad_in(-32768, -32768, -32768, -32768, -32768, -32768, 32767,
                                        32767, 11520), 1'b1,
                                quad_res(0, 0, 0, 0, 0, 0, -32768, -32768)});
    // Odd angles, wrap beyond a full turn and a wide quad go to the predictor.
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, 2880),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, 1),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(-100, -100, 100, -100, 100, 100, -100, 100, -1),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(40, -300, 900, 25, 512, 700, -800, 333, 5759),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(40, -300, 900, 25, 512, 700, -800, 333, 5761),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(40, -300, 900, 25, 512, 700, -800, 333, 23039),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(40, -300, 900, 25, 512, 700, -800, 333, 32767),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(40, -300, 900, 25, 512, 700, -800, 333, -32768),
                                1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(32767, -32768, -32768, 32767, 32767, 32767, -32768,
                                        -32768, 2880), 1'b0, '0});
    plan.push_back(quad_case_t'{quad_in(0, 0, 1, 0, 0, 0, 0, 1, 11521), 1'b0, '0});
    while (!rst_n) @(posedge clk);
    foreach (plan[i]) begin
      offer_quad(plan[i].stim, plan[i].fixed, plan[i].res);
    end
    for (int n = 0; n < RANDOM_QUADS; n++) begin
      offer_quad(random_quad(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Sink: ready patterns that change every span, plus one long hold-off.
  initial begin : sink
    int  span, mode;
    bit  held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && quads_sent >= HOLD_OFF_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        held = 1'b1;
      end
      span = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      for (int n = 0; n < span; n++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 7) != 0);
          default: out_tready <= ((n % 4) != 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Scoreboard: predict on each accepted quad, compare each accepted result.
  always @(posedge clk) begin : scoreboard
    logic [OUT_DATA_W-1:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rotated_due.push_back(cur_fixed ? cur_fixed_res : rotate_about_centroid(in_tdata));
        quads_sent++;
      end
      if (out_tvalid && out_tready) begin
        if (rotated_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result transaction %0d arrived with no quad outstanding: %h",
                     quads_checked, out_tdata);
          end
        end else begin
          want = rotated_due.pop_front();
          for (int f = 0; f < 2 * NUM_VERT; f++) begin
            if (out_tdata[f*COORD_BITS +: COORD_BITS] !== want[f*COORD_BITS +: COORD_BITS])
            begin
              mismatch_count++;
              if (mismatch_count <= 10) begin
                $display("result %0d %s%0d: expected %0d, got %0d", quads_checked,
                         (f % 2) ? "ry" : "rx", f / 2,
                         $signed(want[f*COORD_BITS +: COORD_BITS]),
                         $signed(out_tdata[f*COORD_BITS +: COORD_BITS]));
              end
            end
          end
        end
        quads_checked++;
      end
    end
  end

  // Reset, then wait for all results and let the pipeline drain.
  initial begin : main
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && rotated_due.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog on the total cycle count.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
